@@ src/fut_pkg.sv @@
package fut_pkg;

    // Input beat: one raw byte of the form body
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // Output beat: one decoded byte and/or part boundary flags
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       in_value;
        logic       key_done;
        logic       pair_done;
        logic       run_last;
    } t_out;

    // Escape tracking codes
    localparam logic [1:0] PEND_NONE  = 2'd0;  // no escape open
    localparam logic [1:0] PEND_PCT   = 2'd1;  // '%' seen
    localparam logic [1:0] PEND_DIGIT = 2'd2;  // '%' and first digit seen

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    // Hex digit value; anything that is not a hex digit counts as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            v = c - CH_0;
        end else if (c >= CH_LA && c <= CH_LF) begin
            v = c - CH_LA + HEX_TEN;
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = c - CH_UA + HEX_TEN;
        end
        return v[3:0];
    endfunction

    // '+' decodes to a space, all else passes
    function automatic logic [7:0] plain_byte(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    // Build one result beat; run_last is patched in by the caller
    function automatic t_out mk_res(input logic [7:0] b, input logic valid,
                                    input logic inval, input logic kd,
                                    input logic pd);
        t_out r;
        r.out_byte   = valid ? b : 8'd0;
        r.byte_valid = valid;
        r.in_value   = inval;
        r.key_done   = kd;
        r.pair_done  = pd;
        r.run_last   = 1'b0;
        return r;
    endfunction

endpackage

@@ src/form_urlencoded_tokenizer_core.sv @@
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_ready    | i_in  (t_in: byte, last flag)
// out     | output    | o_out_valid / i_out_ready  | o_out (t_out: decoded byte, flags)
//
// One input beat per cycle while the queue has room (o_in_ready); decode is a
// single combinational pass from the accepted byte and escape state into a
// 3-entry result queue. An input beat makes 0, 1 or 2 result beats; a
// two-result beat fills two queue entries, and the input may stall while
// they drain. Results are registered in the queue before reaching o_out.
// Reset (synchronous, active low) empties the queue and clears escape state.
// o_in_ready depends only on queue occupancy, never on i_out_ready.
module form_urlencoded_tokenizer_core
    import fut_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int QDEPTH = 3;

    logic [1:0] r_pcnt, n_pcnt;
    logic [7:0] r_pdig, n_pdig;
    logic       r_vpart, n_vpart;

    t_out       r_q [QDEPTH];
    logic [1:0] r_wr, r_rd, r_cnt;
    logic [1:0] wr_nxt, rd_nxt, wr_p2;

    logic       acc, pop;
    logic [1:0] n_push;
    t_out       res0, res1;

    logic [7:0] b;
    logic       last, amp, keyend, kd, pd, iv;

    assign acc        = i_in_valid && o_in_ready;
    assign pop        = o_out_valid && i_out_ready;
    assign o_in_ready = (r_cnt <= 2'd1);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out      = r_q[r_rd];

    // Decode one byte against the escape state
    always_comb begin
        b       = i_in.in_byte;
        last    = i_in.in_last;
        amp     = (b == CH_AMP);
        keyend  = (b == CH_EQ) && !r_vpart;
        kd      = keyend;
        pd      = amp || last;
        iv      = keyend ? 1'b0 : r_vpart;
        n_pcnt  = r_pcnt;
        n_pdig  = r_pdig;
        n_vpart = r_vpart;
        n_push  = 2'd0;
        res0    = '0;
        res1    = '0;

        if (amp || keyend) begin
            // part terminator; flush a cut-short escape literally
            case (r_pcnt)
                PEND_NONE: begin
                    res0   = mk_res(8'd0, 1'b0, iv, kd, pd);
                    n_push = 2'd1;
                end
                PEND_PCT: begin
                    res0   = mk_res(CH_PCT, 1'b1, iv, kd, pd);
                    n_push = 2'd1;
                end
                default: begin
                    res0   = mk_res(CH_PCT, 1'b1, iv, 1'b0, 1'b0);
                    res1   = mk_res(plain_byte(r_pdig), 1'b1, iv, kd, pd);
                    n_push = 2'd2;
                end
            endcase
            n_pcnt  = PEND_NONE;
            n_pdig  = 8'd0;
            n_vpart = !amp;
        end else begin
            case (r_pcnt)
                PEND_NONE: begin
                    if (b == CH_PCT) begin
                        if (last) begin
                            res0   = mk_res(CH_PCT, 1'b1, r_vpart, 1'b0, 1'b1);
                            n_push = 2'd1;
                        end else begin
                            n_pcnt = PEND_PCT;
                        end
                    end else begin
                        res0   = mk_res(plain_byte(b), 1'b1, r_vpart, 1'b0, last);
                        n_push = 2'd1;
                    end
                end
                PEND_PCT: begin
                    if (last) begin
                        res0   = mk_res(CH_PCT, 1'b1, r_vpart, 1'b0, 1'b0);
                        res1   = mk_res(plain_byte(b), 1'b1, r_vpart, 1'b0, 1'b1);
                        n_push = 2'd2;
                        n_pcnt = PEND_NONE;
                    end else begin
                        n_pdig = b;
                        n_pcnt = PEND_DIGIT;
                    end
                end
                default: begin
                    res0   = mk_res({hex_nibble(r_pdig), hex_nibble(b)}, 1'b1,
                                    r_vpart, 1'b0, last);
                    n_push = 2'd1;
                    n_pcnt = PEND_NONE;
                    n_pdig = 8'd0;
                end
            endcase
        end

        // end of body returns all state to reset
        if (last) begin
            n_pcnt  = PEND_NONE;
            n_pdig  = 8'd0;
            n_vpart = 1'b0;
        end

        // tag the final result of this beat
        if (n_push == 2'd1) begin
            res0.run_last = 1'b1;
        end else if (n_push == 2'd2) begin
            res1.run_last = 1'b1;
        end
    end

    // Queue pointer arithmetic, modulo depth
    always_comb begin
        wr_nxt = (r_wr == 2'(QDEPTH - 1)) ? 2'd0 : r_wr + 2'd1;
        wr_p2  = (wr_nxt == 2'(QDEPTH - 1)) ? 2'd0 : wr_nxt + 2'd1;
        rd_nxt = (r_rd == 2'(QDEPTH - 1)) ? 2'd0 : r_rd + 2'd1;
    end

    // Escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt  <= PEND_NONE;
            r_pdig  <= 8'd0;
            r_vpart <= 1'b0;
        end else if (acc) begin
            r_pcnt  <= n_pcnt;
            r_pdig  <= n_pdig;
            r_vpart <= n_vpart;
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (acc && n_push != 2'd0) begin
            r_q[r_wr] <= res0;
        end
        if (acc && n_push == 2'd2) begin
            r_q[wr_nxt] <= res1;
        end
    end

    // Result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 2'd0;
        end else begin
            if (acc && n_push == 2'd1) begin
                r_wr <= wr_nxt;
            end else if (acc && n_push == 2'd2) begin
                r_wr <= wr_p2;
            end
            if (pop) begin
                r_rd <= rd_nxt;
            end
            r_cnt <= r_cnt + (acc ? n_push : 2'd0) - {1'b0, pop};
        end
    end

    // Escape counter never takes the unused code
    a_pcnt_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt != 2'd3)
        else $error("escape counter in unused code");

    // A body end leaves the tokenizer in its reset state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.in_last) |=> (r_pcnt == PEND_NONE && !r_vpart && r_pdig == 8'd0))
        else $error("state not cleared after last byte");

    // A body end always produces at least one result carrying pair_done
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.in_last) |-> (n_push != 2'd0 &&
            ((n_push == 2'd1 && res0.pair_done) || (n_push == 2'd2 && res1.pair_done))))
        else $error("last byte did not close the pair");

    // Beat with two results marks only the second as final
    a_two_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && n_push == 2'd2) |-> (!res0.run_last && res1.run_last))
        else $error("run_last misplaced on two-result beat");

    // Queue occupancy tracks pushes and pops
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!acc && !pop) |=> $stable(r_cnt))
        else $error("queue count moved without push or pop");

endmodule
